// ----- design/wgm_pkg.sv -----
`timescale 1ns / 1ps

package wgm_pkg;

    // Request codes carried in req_type
    typedef enum logic [1:0] {
        REQ_LOAD = 2'd0,
        REQ_SUBJ = 2'd1,
        REQ_END  = 2'd2
    } t_req;

    localparam logic [7:0] STAR_CHAR = 8'h2A;
    localparam logic [7:0] ANY_CHAR  = 8'h3F;

    localparam int LEN_W = 6;

    typedef struct packed {
        logic start;
        logic failed;
    } t_row_state;

    typedef struct packed {
        logic fail_now;
        logic matched;
    } t_row_status;

endpackage

// ----- design/wildcard_glob_matcher_top.sv -----
`timescale 1ns / 1ps

// An end beat passes through the input register, then the match-row update into
// the result register; a full, stalled result register holds it in the input
// register. Other beats give no result.
// Throughput: one beat per cycle, unless a full, stalled result register holds an end beat.
// Reset (synchronous, active low): clear the match row and length, arm the
// subject start, clear the failed flag; pattern bytes stay undefined.
module wildcard_glob_matcher_top #(
    parameter int MAX_PATTERN = 32
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // input channel
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [1:0] i_req_type,
    input  logic [4:0] i_pattern_index,
    input  logic [7:0] i_char_value,
    // result channel
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic       o_matched,
    // configuration write channel
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [5:0] i_pattern_length
);

    localparam logic [wgm_pkg::LEN_W-1:0] MaxLen = wgm_pkg::LEN_W'(MAX_PATTERN);

    // Input register stage
    logic       r_in_vld;
    logic [1:0] r_in_type;
    logic [4:0] r_in_idx;
    logic [7:0] r_in_char;

    // Matcher state
    logic [7:0]             r_pat_char [MAX_PATTERN];
    logic [MAX_PATTERN:0]   r_row;
    logic                   r_start;
    logic                   r_failed;
    logic [wgm_pkg::LEN_W-1:0] r_pat_len;

    // Result register
    logic r_out_vld;
    logic r_out_matched;

    logic                      w_in_acc;
    logic                      w_out_free;
    logic                      w_fire;
    logic [wgm_pkg::LEN_W-1:0] w_used_len;
    logic [MAX_PATTERN:0]      w_next_row;
    wgm_pkg::t_row_state       w_state;
    wgm_pkg::t_row_status      w_status;

    // The result register is free when empty or being drained this cycle.
    assign w_out_free = ~r_out_vld | ~i_out_stall;
    // Only end beats need a free result slot; every other beat retires at once.
    assign w_fire     = r_in_vld
                        & ((r_in_type != wgm_pkg::REQ_END) | w_out_free);
    assign o_in_stall = r_in_vld & ~w_fire;
    assign w_in_acc   = i_in_valid & ~o_in_stall;

    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_vld;
    assign o_matched   = r_out_matched;

    // Clamp the programmed length to the store depth.
    assign w_used_len = (r_pat_len > MaxLen) ? MaxLen : r_pat_len;

    assign w_state.start  = r_start;
    assign w_state.failed = r_failed;

    wgm_row_step #(
        .MAX_PATTERN (MAX_PATTERN)
    ) u_row_step (
        .i_pat_char  (r_pat_char),
        .i_row       (r_row),
        .i_state     (w_state),
        .i_used_len  (w_used_len),
        .i_subj_char (r_in_char),
        .o_next_row  (w_next_row),
        .o_status    (w_status)
    );

    // Input register: load on accept, drop once the beat retires.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (w_in_acc) begin
            r_in_vld <= 1'b1;
        end else if (w_fire) begin
            r_in_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_in_type <= i_req_type;
            r_in_idx  <= i_pattern_index;
            r_in_char <= i_char_value;
        end
    end

    // Pattern store: one byte per load beat, out-of-range indexes never hit.
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < MAX_PATTERN; k++) begin
            if (w_fire && (r_in_type == wgm_pkg::REQ_LOAD)
                    && ({1'b0, r_in_idx} == 6'(k))) begin
                r_pat_char[k] <= r_in_char;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pat_len <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_pat_len <= i_pattern_length;
        end
    end

    // Match-row state: a subject beat advances the row unless already failed;
    // an end beat clears the row and the failed flag and rearms the subject start.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row    <= '0;
            r_start  <= 1'b1;
            r_failed <= 1'b0;
        end else if (w_fire) begin
            case (r_in_type)
                wgm_pkg::REQ_SUBJ: begin
                    r_start <= 1'b0;
                    if (!r_failed) begin
                        r_row <= w_next_row;
                        if (w_status.fail_now) begin
                            r_failed <= 1'b1;
                        end
                    end
                end
                wgm_pkg::REQ_END: begin
                    r_row    <= '0;
                    r_start  <= 1'b1;
                    r_failed <= 1'b0;
                end
                default: begin
                end
            endcase
        end
    end

    // Result register: fill on an end beat, clear when drained.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_fire && (r_in_type == wgm_pkg::REQ_END)) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && (r_in_type == wgm_pkg::REQ_END)) begin
            r_out_matched <= w_status.matched;
        end
    end

    // An end beat that retires always leaves a result behind.
    a_end_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && (r_in_type == wgm_pkg::REQ_END)) |=> r_out_vld)
        else $error("end beat retired without a result");

    // An end beat rearms the next subject.
    a_end_rearms: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_fire && (r_in_type == wgm_pkg::REQ_END)) |=> (r_start && !r_failed))
        else $error("subject state not rearmed after end beat");

    // A failed subject has always consumed at least one subject beat.
    a_failed_not_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_failed |-> !r_start)
        else $error("failed flag set at subject start");

endmodule

// ----- design/wgm_row_step.sv -----
`timescale 1ns / 1ps

module wgm_row_step #(
    parameter int MAX_PATTERN = 32
) (
    input  logic [7:0]                  i_pat_char [MAX_PATTERN],
    input  logic [MAX_PATTERN:0]        i_row,
    input  wgm_pkg::t_row_state         i_state,
    input  logic [wgm_pkg::LEN_W-1:0]   i_used_len,
    input  logic [7:0]                  i_subj_char,
    output logic [MAX_PATTERN:0]        o_next_row,
    output wgm_pkg::t_row_status        o_status
);

    localparam int SumW = MAX_PATTERN + 2;

    logic [MAX_PATTERN-1:0] w_star;
    logic [MAX_PATTERN-1:0] w_hit;
    logic [MAX_PATTERN-1:0] w_lead;
    logic [MAX_PATTERN:0]   w_init;
    logic [MAX_PATTERN:0]   w_cur;
    logic [SumW-1:0]        w_gen;
    logic [SumW-1:0]        w_prop;
    logic [SumW-1:0]        w_sum;
    logic [SumW-1:0]        w_carry;
    logic                   w_sel;

    // Per-lane pattern classification against the used length
    always_comb begin
        for (int k = 0; k < MAX_PATTERN; k++) begin
            w_star[k] = (6'(k) < i_used_len) && (i_pat_char[k] == wgm_pkg::STAR_CHAR);
            w_hit[k]  = (6'(k) < i_used_len) && (i_pat_char[k] != wgm_pkg::STAR_CHAR)
                        && ((i_pat_char[k] == wgm_pkg::ANY_CHAR)
                            || (i_pat_char[k] == i_subj_char));
        end
    end

    // Leading run of stars: trailing-ones mask of the star vector
    assign w_lead = w_star + MAX_PATTERN'(1);
    assign w_init = {w_star & ~w_lead, 1'b1};
    assign w_cur  = i_state.start ? w_init : i_row;

    // Star lanes propagate the new bit upward; resolve the chain as a carry
    always_comb begin
        w_gen  = '0;
        w_prop = '0;
        for (int k = 0; k < MAX_PATTERN; k++) begin
            w_gen[k+1]  = (w_star[k] & w_cur[k+1]) | (w_hit[k] & w_cur[k]);
            w_prop[k+1] = w_star[k];
        end
    end

    assign w_sum      = (w_gen | w_prop) + w_gen;
    assign w_carry    = w_sum ^ (w_gen | w_prop) ^ w_gen;
    assign o_next_row = w_carry[SumW-1:1];

    always_comb begin
        w_sel = 1'b0;
        for (int i = 0; i <= MAX_PATTERN; i++) begin
            if (6'(i) == i_used_len) begin
                w_sel = w_cur[i];
            end
        end
    end

    assign o_status.fail_now = ~|o_next_row;
    assign o_status.matched  = ~i_state.failed & w_sel;

endmodule

// ----- tb/wildcard_glob_matcher_top_test.sv -----
`timescale 1ns / 1ps

module wildcard_glob_matcher_top_test;

    localparam int          CLK_PERIOD  = 12;
    localparam int          MAX_PAT     = 32;
    localparam int          LAT_SLACK   = 4;
    localparam int          CYCLE_LIMIT = 400000;
    localparam int          PHASE_BEATS = 175;     // four phases give about 700 beats
    localparam logic [1:0]  REQ_UNUSED  = 2'd3;    // code the block must ignore

    logic       i_clk = 1'b0;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_stall;
    logic [1:0] i_req_type;
    logic [4:0] i_pattern_index;
    logic [7:0] i_char_value;
    logic       o_out_valid;
    logic       i_out_stall;
    logic       o_matched;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [5:0] i_pattern_length;

    // Predictor state: pattern bytes, match row, subject flags, length register.
    logic [7:0]  pat_mem [MAX_PAT];
    logic [32:0] match_row;
    logic        subj_start;
    logic        subj_failed;
    logic [5:0]  cfg_len;

    // Expected match flags, oldest first, one per accepted end beat.
    logic        pending_matched [$];
    logic [7:0]  subject_bytes [$];

    int          send_idle_pct;
    int          rx_stall_pct;
    int          beats_sent;
    int          results_checked;
    int          hits_seen;
    int          mismatches;
    int unsigned cycle_count;
    logic        want_matched;

    wildcard_glob_matcher_top #(
        .MAX_PATTERN(MAX_PAT)
    ) i_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_req_type       (i_req_type),
        .i_pattern_index  (i_pattern_index),
        .i_char_value     (i_char_value),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_matched        (o_matched),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_pattern_length (i_pattern_length)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // Hard stop: a hung handshake must not run forever.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d results still pending", $time,
                     pending_matched.size());
            $display("wildcard_glob_matcher_top verification failed");
            $finish;
        end
    end

    // Receiver: stall the result channel at the rate the current phase asks.
    always @(negedge i_clk) begin
        i_out_stall <= ($urandom_range(99) < rx_stall_pct);
    end

    // Check every accepted result beat against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_matched.size() == 0) begin
                $display("%0t: result with nothing expected, expected none actual matched=%0b",
                         $time, o_matched);
                mismatches++;
            end else begin
                want_matched = pending_matched.pop_front();
                results_checked++;
                if (want_matched)
                    hits_seen++;
                if (o_matched !== want_matched) begin
                    $display("%0t: matched mismatch, expected %0b actual %0b",
                             $time, want_matched, o_matched);
                    mismatches++;
                end
            end
        end
    end

    // Advance the predicted glob state by one accepted beat.
    task automatic apply_glob_beat(input logic [1:0] kind, input logic [4:0] idx,
                                   input logic [7:0] ch);
        int          eff;
        logic [32:0] next_row;
        eff = (cfg_len > MAX_PAT) ? MAX_PAT : int'(cfg_len);
        // Arm the row on the first subject or end beat: bit 0 plus any leading stars.
        if ((kind == wgm_pkg::REQ_SUBJ || kind == wgm_pkg::REQ_END) && subj_start) begin
            match_row    = '0;
            match_row[0] = 1'b1;
            for (int i = 1; i <= eff; i++) begin
                if (pat_mem[i - 1] != wgm_pkg::STAR_CHAR)
                    break;
                match_row[i] = 1'b1;
            end
            subj_start = 1'b0;
        end
        case (kind)
            wgm_pkg::REQ_LOAD: pat_mem[idx] = ch;
            wgm_pkg::REQ_SUBJ: begin
                // A failed subject swallows the rest of its bytes.
                if (!subj_failed) begin
                    next_row = '0;
                    for (int i = 1; i <= eff; i++) begin
                        if (pat_mem[i - 1] == wgm_pkg::STAR_CHAR)
                            next_row[i] = next_row[i - 1] | match_row[i];
                        else if (pat_mem[i - 1] == wgm_pkg::ANY_CHAR
                                 || pat_mem[i - 1] == ch)
                            next_row[i] = match_row[i - 1];
                    end
                    match_row = next_row;
                    if (next_row == '0)
                        subj_failed = 1'b1;
                end
            end
            wgm_pkg::REQ_END: begin
                pending_matched.push_back(subj_failed ? 1'b0 : match_row[eff]);
                match_row   = '0;
                subj_start  = 1'b1;
                subj_failed = 1'b0;
            end
            default: ;
        endcase
    endtask

    // Send one beat: idle at random, hold the payload through stalls, then predict.
    // Valid stays high after acceptance; the next call or a drain decides its fate.
    task automatic send_beat(input logic [1:0] kind, input logic [4:0] idx,
                             input logic [7:0] ch);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_req_type      <= kind;
        i_pattern_index <= idx;
        i_char_value    <= ch;
        do
            @(posedge i_clk);
        while (o_in_stall);
        apply_glob_beat(kind, idx, ch);
        if (kind != REQ_UNUSED)
            beats_sent++;
    endtask

    // Drop valid, wait for every pending result, then let the pipeline empty.
    task automatic wait_quiet();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (pending_matched.size() != 0)
            @(posedge i_clk);
        repeat (LAT_SLACK) @(posedge i_clk);
    endtask

    // Write the pattern length register; call only when the block is quiet.
    task automatic write_length(input logic [5:0] len);
        @(negedge i_clk);
        i_cfg_valid      <= 1'b1;
        i_pattern_length <= len;
        do
            @(posedge i_clk);
        while (!o_cfg_ready);
        cfg_len = len;
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Subject filler: mostly a tiny alphabet so literals hit, sometimes any byte.
    function automatic logic [7:0] pick_byte();
        if ($urandom_range(3) == 0)
            return 8'($urandom_range(255));
        return 8'("a") + 8'($urandom_range(2));
    endfunction

    function automatic logic [7:0] pick_pattern_byte();
        case ($urandom_range(9))
            0, 1: return wgm_pkg::STAR_CHAR;
            2:    return wgm_pkg::ANY_CHAR;
            3:    return 8'($urandom_range(255));
            default: return 8'("a") + 8'($urandom_range(2));
        endcase
    endfunction

    // Mostly small lengths, with the empty pattern, the full store and
    // oversized values mixed in.
    function automatic logic [5:0] pick_length();
        case ($urandom_range(15))
            0: return 6'd0;
            1: return 6'd32;
            2: return 6'($urandom_range(63, 33));
            default: return 6'($urandom_range(8, 1));
        endcase
    endfunction

    // Build a subject that fits the stored pattern, then maybe break it.
    task automatic run_subject(input int eff);
        int pos;
        subject_bytes.delete();
        for (int i = 0; i < eff; i++) begin
            if (pat_mem[i] == wgm_pkg::STAR_CHAR) begin
                repeat ($urandom_range(3)) subject_bytes.push_back(pick_byte());
            end else if (pat_mem[i] == wgm_pkg::ANY_CHAR) begin
                subject_bytes.push_back(pick_byte());
            end else begin
                subject_bytes.push_back(pat_mem[i]);
            end
        end
        case ($urandom_range(9))
            0: if (subject_bytes.size() > 0) begin
                pos = $urandom_range(subject_bytes.size() - 1);
                subject_bytes[pos] = pick_byte();
            end
            1: if (subject_bytes.size() > 0) begin
                subject_bytes.delete($urandom_range(subject_bytes.size() - 1));
            end
            2: subject_bytes.insert($urandom_range(subject_bytes.size()), pick_byte());
            3: begin
                subject_bytes.delete();
                repeat ($urandom_range(6)) subject_bytes.push_back(pick_byte());
            end
            default: ;
        endcase
        foreach (subject_bytes[k]) begin
            // Sprinkle ignored codes and pattern rewrites inside the subject.
            case ($urandom_range(24))
                0: send_beat(REQ_UNUSED, 5'($urandom), 8'($urandom));
                1: if (eff > 0) begin
                    send_beat(wgm_pkg::REQ_LOAD, 5'($urandom_range(eff - 1)),
                              pick_pattern_byte());
                end
                default: ;
            endcase
            send_beat(wgm_pkg::REQ_SUBJ, 5'($urandom), subject_bytes[k]);
        end
        send_beat(wgm_pkg::REQ_END, 5'($urandom), 8'($urandom));
    endtask

    // Load a fresh pattern, set its length while quiet, then run a few subjects.
    task automatic run_pattern_round(input logic [5:0] len);
        int eff;
        eff = (len > MAX_PAT) ? MAX_PAT : int'(len);
        for (int i = 0; i < eff; i++)
            send_beat(wgm_pkg::REQ_LOAD, 5'(i), pick_pattern_byte());
        wait_quiet();
        write_length(len);
        repeat ($urandom_range(6, 3)) run_subject(eff);
    endtask

    // Empty pattern after reset: only the empty subject matches.
    task automatic test_empty_pattern();
        send_beat(wgm_pkg::REQ_END, 5'd0, 8'h00);
        send_beat(wgm_pkg::REQ_SUBJ, 5'd31, 8'hFF);
        send_beat(wgm_pkg::REQ_END, 5'd0, 8'h00);
        wait_quiet();
        write_length(6'd0);
    endtask

    // Star, any and a zero byte; includes the empty subject against leading star.
    task automatic test_wildcards();
        send_beat(wgm_pkg::REQ_LOAD, 5'd0, wgm_pkg::STAR_CHAR);
        send_beat(wgm_pkg::REQ_LOAD, 5'd1, wgm_pkg::ANY_CHAR);
        send_beat(wgm_pkg::REQ_LOAD, 5'd2, 8'h00);
        wait_quiet();
        write_length(6'd3);
        send_beat(wgm_pkg::REQ_SUBJ, 5'd0, 8'("q"));
        send_beat(wgm_pkg::REQ_SUBJ, 5'd0, 8'("r"));
        send_beat(wgm_pkg::REQ_SUBJ, 5'd0, 8'h00);
        send_beat(wgm_pkg::REQ_END, 5'd0, 8'h00);
        send_beat(wgm_pkg::REQ_END, 5'd0, 8'h00);
    endtask

    // Fail the subject early; later bytes are ignored until the end beat.
    task automatic test_failed_subject();
        send_beat(wgm_pkg::REQ_LOAD, 5'd0, 8'hFF);
        send_beat(wgm_pkg::REQ_LOAD, 5'd31, 8'hA5);
        send_beat(wgm_pkg::REQ_SUBJ, 5'd0, 8'h7F);
        send_beat(wgm_pkg::REQ_SUBJ, 5'd0, 8'hFF);
        send_beat(wgm_pkg::REQ_END, 5'd0, 8'h00);
    endtask

    // Rewrite a pattern byte and slip in an unused code mid-subject.
    task automatic test_midsubject_changes();
        send_beat(wgm_pkg::REQ_SUBJ, 5'd0, 8'hFF);
        send_beat(wgm_pkg::REQ_LOAD, 5'd2, 8'("z"));
        send_beat(wgm_pkg::REQ_SUBJ, 5'd0, 8'("k"));
        send_beat(REQ_UNUSED, 5'd31, 8'hFF);
        send_beat(wgm_pkg::REQ_SUBJ, 5'd0, 8'("z"));
        send_beat(wgm_pkg::REQ_END, 5'd0, 8'h00);
        wait_quiet();
    endtask

    // One idle/stall mix: the first round uses a forced length, the rest random.
    task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                       input logic [5:0] first_len);
        int phase_start;
        send_idle_pct = idle_pct;
        rx_stall_pct  = stall_pct;
        phase_start   = beats_sent;
        run_pattern_round(first_len);
        while (beats_sent - phase_start < PHASE_BEATS)
            run_pattern_round(pick_length());
        // Hold the sender until every pending result is back.
        wait_quiet();
    endtask

    initial begin
        i_rst_n          = 1'b0;
        i_in_valid       = 1'b0;
        i_req_type       = wgm_pkg::REQ_LOAD;
        i_pattern_index  = '0;
        i_char_value     = '0;
        i_out_stall      = 1'b0;
        i_cfg_valid      = 1'b0;
        i_pattern_length = '0;
        send_idle_pct    = 0;
        rx_stall_pct     = 0;
        beats_sent       = 0;
        results_checked  = 0;
        hits_seen        = 0;
        mismatches       = 0;
        cycle_count      = 0;
        foreach (pat_mem[i])
            pat_mem[i] = '0;
        match_row   = '0;
        subj_start  = 1'b1;
        subj_failed = 1'b0;
        cfg_len     = '0;

        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_empty_pattern();
        test_wildcards();
        test_failed_subject();
        test_midsubject_changes();

        test_random_traffic(0, 0, 6'd0);
        test_random_traffic(52, 0, 6'd32);
        test_random_traffic(0, 52, 6'd63);
        test_random_traffic(33, 33, 6'd33);

        wait_quiet();

        $display("Run covered %0d beats and %0d end results (%0d matches), %0d mismatches,",
                 beats_sent, results_checked, hits_seen, mismatches);
        $display("over pattern lengths 0 to 63 and four sender/receiver idle mixes.");
        if (mismatches == 0 && pending_matched.size() == 0)
            $display("wildcard_glob_matcher_top verification clean");
        else
            $display("wildcard_glob_matcher_top verification failed");
        $finish;
    end

endmodule
